// ===== src/pcmc_pkg.sv =====
// Shared types and command codes for the PCM playback channel control block.
// No dependencies; imported by pcmc_core and pcm_playback_channel_control.
`default_nettype none

package pcmc_pkg;

    // Command codes, carried on s_tuser.
    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_PLAY     = 3'd1,
        CMD_STOP     = 3'd2,
        CMD_PAUSE    = 3'd3,
        CMD_RESUME   = 3'd4,
        CMD_SEEK     = 3'd5,
        CMD_SET_VOL  = 3'd6,
        CMD_SET_RATE = 3'd7
    } cmd_t;

    localparam int ADDR_W  = 28;
    localparam int LEN_W   = 16;
    localparam int RATE_W  = 16;
    localparam int FMT_W   = 2;
    localparam int VOL_IN_W = 16;
    localparam int VOL_W   = 8;

    localparam int IN_DATA_W  = 96;   // 95 payload bits padded to bytes
    localparam int OUT_DATA_W = 48;   // 46 result bits padded to bytes

    // Status codes.
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef struct packed {
        cmd_t                        cmd;
        logic [ADDR_W-1:0]           sample_addr;
        logic [LEN_W-1:0]            sample_length;
        logic [RATE_W-1:0]           play_rate;
        logic [FMT_W-1:0]            sample_format;
        logic                        loop_enable;
        logic [LEN_W-1:0]            seek_position;
        logic signed [VOL_IN_W-1:0]  volume_level;
    } cmd_item_t;

    typedef struct packed {
        logic               status;
        logic               now_playing;
        logic               is_paused;
        logic               position_valid;
        logic [LEN_W-1:0]   play_position;
        logic [VOL_W-1:0]   current_volume;
        logic [RATE_W-1:0]  current_rate;
        logic [FMT_W-1:0]   sample_fmt;
    } result_t;

endpackage

`default_nettype wire

// ===== src/pcmc_core.sv =====
// Channel state registers and the per-command next-state / result logic.
// Depends on pcmc_pkg.
`default_nettype none

module pcmc_core
    import pcmc_pkg::*;
#(
    parameter int MAX_SAMPLE_LEN = 65535,
    parameter int VOLUME_MIN     = 0,
    parameter int VOLUME_MAX     = 255,
    parameter int VOLUME_RESET   = 255,
    parameter int FREQ_RESET     = 8000
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      advance,   // commit item and its state update
    input  wire cmd_item_t item,
    output result_t        result
);

    localparam logic signed [VOL_IN_W:0] VMIN_S = (VOL_IN_W+1)'(VOLUME_MIN);
    localparam logic signed [VOL_IN_W:0] VMAX_S = (VOL_IN_W+1)'(VOLUME_MAX);
    localparam logic [LEN_W:0]           MAX_LEN = (LEN_W+1)'(MAX_SAMPLE_LEN);

    logic                loaded_reg,   loaded_next;
    logic                playing_reg,  playing_next;
    logic                paused_reg,   paused_next;
    logic [ADDR_W-1:0]   base_addr_reg, base_addr_next;
    logic [LEN_W-1:0]    length_reg,   length_next;
    logic [LEN_W-1:0]    position_reg, position_next;
    logic [RATE_W-1:0]   rate_reg,     rate_next;
    logic [FMT_W-1:0]    format_reg,   format_next;
    logic                looping_reg,  looping_next;
    logic [VOL_W-1:0]    volume_reg,   volume_next;
    logic                status;

    logic [LEN_W:0]           pos_inc;
    logic signed [VOL_IN_W:0] vol_ext;
    logic signed [VOL_IN_W:0] vol_lo;
    logic signed [VOL_IN_W:0] vol_clamped;
    logic                     play_bad;

    assign pos_inc  = {1'b0, position_reg} + (LEN_W+1)'(1);
    assign vol_ext  = {item.volume_level[VOL_IN_W-1], item.volume_level};
    // raise to the floor first, then lower to the ceiling
    assign vol_lo      = (vol_ext < VMIN_S) ? VMIN_S : vol_ext;
    assign vol_clamped = (vol_lo > VMAX_S) ? VMAX_S : vol_lo;
    assign play_bad = (item.sample_addr == '0) || (item.sample_length == '0)
                   || (item.play_rate == '0)
                   || ({1'b0, item.sample_length} > MAX_LEN);

    always_comb
    begin
        loaded_next    = loaded_reg;
        playing_next   = playing_reg;
        paused_next    = paused_reg;
        base_addr_next = base_addr_reg;
        length_next    = length_reg;
        position_next  = position_reg;
        rate_next      = rate_reg;
        format_next    = format_reg;
        looping_next   = looping_reg;
        volume_next    = volume_reg;
        status         = STATUS_OK;
        case (item.cmd)
            CMD_TICK:
            begin
                if (playing_reg && loaded_reg)
                begin
                    position_next = pos_inc[LEN_W-1:0];
                    if (pos_inc >= {1'b0, length_reg})
                    begin
                        if (looping_reg)
                            position_next = '0;
                        else
                        begin
                            // end of sample: position is left at the length
                            playing_next = 1'b0;
                            loaded_next  = 1'b0;
                        end
                    end
                end
            end
            CMD_PLAY:
            begin
                if (play_bad)
                    status = STATUS_REJECT;
                else
                begin
                    loaded_next    = 1'b1;
                    base_addr_next = item.sample_addr;
                    length_next    = item.sample_length;
                    position_next  = '0;
                    rate_next      = item.play_rate;
                    format_next    = item.sample_format;
                    looping_next   = item.loop_enable;
                    playing_next   = 1'b1;
                    paused_next    = 1'b0;
                end
            end
            CMD_STOP:
            begin
                playing_next  = 1'b0;
                paused_next   = 1'b0;
                loaded_next   = 1'b0;
                position_next = '0;
            end
            CMD_PAUSE:
            begin
                if (playing_reg && !paused_reg)
                begin
                    paused_next  = 1'b1;
                    playing_next = 1'b0;
                end
            end
            CMD_RESUME:
            begin
                if (loaded_reg && paused_reg)
                begin
                    paused_next  = 1'b0;
                    playing_next = 1'b1;
                end
            end
            CMD_SEEK:
            begin
                if (!loaded_reg || (item.seek_position >= length_reg))
                    status = STATUS_REJECT;
                else
                    position_next = item.seek_position;
            end
            CMD_SET_VOL:
                volume_next = vol_clamped[VOL_W-1:0];
            CMD_SET_RATE:
            begin
                if (item.play_rate != '0)
                    rate_next = item.play_rate;
            end
            default:
            begin
                status = STATUS_OK;
            end
        endcase
    end

    // Result is a snapshot of the state after this item.
    always_comb
    begin
        result.status         = status;
        result.now_playing    = playing_next;
        result.is_paused      = paused_next;
        result.position_valid = playing_next || paused_next;
        result.play_position  = (playing_next || paused_next) ? position_next : '0;
        result.current_volume = volume_next;
        result.current_rate   = rate_next;
        result.sample_fmt     = format_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg    <= 1'b0;
            playing_reg   <= 1'b0;
            paused_reg    <= 1'b0;
            base_addr_reg <= '0;
            length_reg    <= '0;
            position_reg  <= '0;
            rate_reg      <= RATE_W'(FREQ_RESET);
            format_reg    <= '0;
            looping_reg   <= 1'b0;
            volume_reg    <= VOL_W'(VOLUME_RESET);
        end
        else if (advance)
        begin
            loaded_reg    <= loaded_next;
            playing_reg   <= playing_next;
            paused_reg    <= paused_next;
            base_addr_reg <= base_addr_next;
            length_reg    <= length_next;
            position_reg  <= position_next;
            rate_reg      <= rate_next;
            format_reg    <= format_next;
            looping_reg   <= looping_next;
            volume_reg    <= volume_next;
        end
    end

    // A playing channel always has a sample loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        playing_reg |-> loaded_reg)
        else $error("pcmc_core: playing without a loaded sample");

    // Playing and paused never hold together.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(playing_reg && paused_reg))
        else $error("pcmc_core: playing and paused both set");

    // While playing the position stays inside the sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        playing_reg |-> (position_reg < length_reg))
        else $error("pcmc_core: position beyond sample length while playing");

endmodule

`default_nettype wire

// ===== src/pcm_playback_channel_control.sv =====
// Top level of the PCM playback channel control: stream ports, input and result registers.
// Depends on pcmc_pkg and pcmc_core.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  command | s_tvalid / s_tready | s_tuser = cmd, s_tdata = operands
//  result  | m_tvalid / m_tready | m_tdata = status, flags, position, settings
//
// One item per cycle sustained while m_tready stays high. An accepted item is
// held in the input register, then the channel state updates and its result
// is captured in the output register on the same edge, which raises m_tvalid;
// that edge waits while a held result blocks the output register.
// Reset (rst_n low, async) clears both stages and loads the channel defaults
// (rate FREQ_RESET, volume VOLUME_RESET). A stalled m_tready holds the result;
// one more item is still taken into the input register, after which s_tready
// drops until the result is taken.
`default_nettype none

module pcm_playback_channel_control
    import pcmc_pkg::*;
#(
    parameter int MAX_SAMPLE_LEN = 65535,
    parameter int VOLUME_MIN     = 0,
    parameter int VOLUME_MAX     = 255,
    parameter int VOLUME_RESET   = 255,
    parameter int FREQ_RESET     = 8000
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [27:0] sample_addr, [43:28] sample_length, [59:44] play_rate,
    // [61:60] sample_format, [62] loop_enable, [78:63] seek_position,
    // [94:79] volume_level, [95] zero
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // [2:0] cmd
    input  wire logic [2:0]            s_tuser,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [0] status, [1] now_playing, [2] is_paused, [3] position_valid,
    // [19:4] play_position, [27:20] current_volume, [43:28] current_rate,
    // [45:44] sample_fmt, [47:46] zero
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    cmd_item_t in_item_reg, in_item_next;
    logic      in_valid_reg, in_valid_next;
    result_t   res_reg;
    logic      out_valid_reg, out_valid_next;
    result_t   res_core;
    logic      s_fire, m_fire, advance;

    // unpack the command item
    always_comb
    begin
        in_item_next.cmd           = cmd_t'(s_tuser);
        in_item_next.sample_addr   = s_tdata[27:0];
        in_item_next.sample_length = s_tdata[43:28];
        in_item_next.play_rate     = s_tdata[59:44];
        in_item_next.sample_format = s_tdata[61:60];
        in_item_next.loop_enable   = s_tdata[62];
        in_item_next.seek_position = s_tdata[78:63];
        in_item_next.volume_level  = s_tdata[94:79];
    end

    // input stage moves on when the result register is free or emptying
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = out_valid_reg && m_tready;

    assign in_valid_next  = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_fire ? 1'b0 : out_valid_reg);

    pcmc_core #(
        .MAX_SAMPLE_LEN (MAX_SAMPLE_LEN),
        .VOLUME_MIN     (VOLUME_MIN),
        .VOLUME_MAX     (VOLUME_MAX),
        .VOLUME_RESET   (VOLUME_RESET),
        .FREQ_RESET     (FREQ_RESET)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .result  (res_core)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_fire)
            in_item_reg <= in_item_next;
        if (advance)
            res_reg <= res_core;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       res_reg.sample_fmt,
                       res_reg.current_rate,
                       res_reg.current_volume,
                       res_reg.play_position,
                       res_reg.position_valid,
                       res_reg.is_paused,
                       res_reg.now_playing,
                       res_reg.status};

    // A committed item always shows up as a result on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("pcmc: committed item produced no result");

    // A held item in the input stage is never dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("pcmc: pending item lost");

    // Position is only reported while playing or paused.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !res_reg.position_valid) |-> (res_reg.play_position == '0))
        else $error("pcmc: position reported while not valid");

endmodule

`default_nettype wire
